>>> hdl/exact_color_palette_indexer_unit_assert.svh
// Assertion macros shared by the palette indexer RTL
`ifndef EXACT_COLOR_PALETTE_INDEXER_UNIT_ASSERT_SVH
`define EXACT_COLOR_PALETTE_INDEXER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Clocked check, masked while reset is asserted
`define ECPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds across reset
`define ECPI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ECPI_ASSERT(label, prop, msg)
`define ECPI_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> hdl/ecpi_pkg.sv
// Shared types, widths and helper functions for the palette indexer
`default_nettype none
package ecpi_pkg;

  localparam int PIXEL_W = 16;
  localparam int COMP_W  = 5;
  localparam int COLOR_W = 3 * COMP_W;
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } ecpi_state_t;

  // Write request into the tail of the cell ring
  typedef struct packed {
    logic               en;
    logic [COLOR_W-1:0] color;
  } ring_wr_t;

  // Pack the three 5-bit components of a pixel, bit 5 is dropped
  function automatic logic [COLOR_W-1:0] pixel_key(input logic [PIXEL_W-1:0] px);
    pixel_key = {px[15:11], px[10:6], px[4:0]};
  endfunction

  // Widen a 5-bit component to 8 bits by repeating its top bits
  function automatic logic [CHAN_W-1:0] expand5(input logic [COMP_W-1:0] c);
    expand5 = {c, c[COMP_W-1:COMP_W-3]};
  endfunction

endpackage
`default_nettype wire

>>> hdl/ecpi_cell.sv
// One palette cell: holds a colour and takes its neighbour's colour each cycle, or a written one
`default_nettype none
module ecpi_cell (
  input  wire logic                        clk,
  input  wire logic [ecpi_pkg::COLOR_W-1:0] nb_color,
  input  wire ecpi_pkg::ring_wr_t           wr,
  output logic      [ecpi_pkg::COLOR_W-1:0] color
);
  import ecpi_pkg::*;

  logic [COLOR_W-1:0] color_r;
  logic [COLOR_W-1:0] color_nxt;

  // Replace the passing colour when a write is requested
  always_comb begin
    color_nxt = wr.en ? wr.color : nb_color;
  end

  // Hold the colour, no reset on payload
  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign color = color_r;

endmodule
`default_nettype wire

>>> hdl/ecpi_ring.sv
// Circular chain of palette cells rotating one place per cycle
`default_nettype none
module ecpi_ring #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                         clk,
  input  wire ecpi_pkg::ring_wr_t           wr,
  output logic      [ecpi_pkg::COLOR_W-1:0] head_color
);
  import ecpi_pkg::*;

  localparam ring_wr_t NO_WR = '{en: 1'b0, color: '0};

  logic [COLOR_W-1:0] cell_q [PALETTE_ENTRIES];

  // Each cell takes from the next one; the tail takes the head back, or a new colour
  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    if (i == PALETTE_ENTRIES - 1) begin : g_tail
      ecpi_cell u_cell (
        .clk      (clk),
        .nb_color (cell_q[0]),
        .wr       (wr),
        .color    (cell_q[i])
      );
    end else begin : g_body
      ecpi_cell u_cell (
        .clk      (clk),
        .nb_color (cell_q[i+1]),
        .wr       (NO_WR),
        .color    (cell_q[i])
      );
    end
  end

  assign head_color = cell_q[0];

endmodule
`default_nettype wire

>>> hdl/exact_color_palette_indexer_unit.sv
// Top level of the exact colour palette indexer
// Each item is compared with the entry at the ring head as the ring rotates, until the
//   matching entry reaches the head cell or, on a miss, every entry has passed it.
// The input stalls while an item is scanned or waits to load into the output register.
// An item is taken while an earlier result still waits in the output register.
// Reset clears the controller, the entry count and the output valid; cell contents are
//   left as they are and are never compared before being written.
`default_nettype none
`include "exact_color_palette_indexer_unit_assert.svh"
module exact_color_palette_indexer_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ecpi_pkg::PIXEL_W-1:0] in_pixel,
  input  wire logic                         in_start_image,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [ecpi_pkg::IDX_W-1:0]   out_color_index,
  output logic                              out_is_new,
  output logic      [ecpi_pkg::CHAN_W-1:0]  out_red_out,
  output logic      [ecpi_pkg::CHAN_W-1:0]  out_green_out,
  output logic      [ecpi_pkg::CHAN_W-1:0]  out_blue_out,
  output logic                              out_overflow,
  output logic      [ecpi_pkg::CNT_W-1:0]   out_entries_used
);
  import ecpi_pkg::*;

  localparam int IW = $clog2(PALETTE_ENTRIES);
  localparam int CW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [IW-1:0] ROT_LAST = IW'(PALETTE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(PALETTE_ENTRIES);

  ecpi_state_t        state_r, state_nxt;
  logic [IW-1:0]      rot_r, rot_nxt;
  logic [IW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [COLOR_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic               res_new_r, res_new_nxt;
  logic               res_ovf_r, res_ovf_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [IDX_W-1:0]   out_color_index_r;
  logic               out_is_new_r;
  logic [CHAN_W-1:0]  out_red_out_r;
  logic [CHAN_W-1:0]  out_green_out_r;
  logic [CHAN_W-1:0]  out_blue_out_r;
  logic               out_overflow_r;
  logic [CNT_W-1:0]   out_entries_used_r;

  logic               in_accept;
  logic               out_free;
  logic               head_used;
  logic               head_hit;
  logic               full;
  ring_wr_t           ring_wr;
  logic [COLOR_W-1:0] head_color;

  // Palette ring
  ecpi_ring #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_ring (
    .clk        (clk),
    .wr         (ring_wr),
    .head_color (head_color)
  );

  // Handshake terms
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Compare at the ring head; rot_r names the entry sitting there
  assign full      = (count_r == CNT_FULL);
  assign head_used = (CW'(rot_r) < count_r);
  assign head_hit  = head_used && (head_color == key_r);

  // Park the new colour in the first free slot as it passes; it only counts on a miss
  always_comb begin
    ring_wr.en    = (state_r == ST_SCAN) && !full && (CW'(rot_r) == count_r);
    ring_wr.color = key_r;
  end

  // Advance the ring position every cycle
  always_comb begin
    rot_nxt = (rot_r == ROT_LAST) ? '0 : rot_r + 1'b1;
  end

  // Next state and item bookkeeping
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    res_idx_nxt = res_idx_r;
    res_new_nxt = res_new_r;
    res_ovf_nxt = res_ovf_r;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          key_nxt   = pixel_key(in_pixel);
          step_nxt  = '0;
          if (in_start_image) begin
            count_nxt = '0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (head_hit) begin
          res_idx_nxt = IDX_W'(rot_r);
          res_new_nxt = 1'b0;
          res_ovf_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end else if (step_r == ROT_LAST) begin
          if (full) begin
            res_idx_nxt = '0;
            res_new_nxt = 1'b0;
            res_ovf_nxt = 1'b1;
          end else begin
            res_idx_nxt = IDX_W'(count_r);
            res_new_nxt = 1'b1;
            res_ovf_nxt = 1'b0;
            count_nxt   = count_r + 1'b1;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_r       <= rot_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    key_r     <= key_nxt;
    res_idx_r <= res_idx_nxt;
    res_new_r <= res_new_nxt;
    res_ovf_r <= res_ovf_nxt;
  end

  // Load the result item
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_color_index_r  <= res_idx_r;
      out_is_new_r       <= res_new_r;
      out_overflow_r     <= res_ovf_r;
      out_red_out_r      <= expand5(key_r[3*COMP_W-1:2*COMP_W]);
      out_green_out_r    <= expand5(key_r[2*COMP_W-1:COMP_W]);
      out_blue_out_r     <= expand5(key_r[COMP_W-1:0]);
      out_entries_used_r <= CNT_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_color_index  = out_color_index_r;
  assign out_is_new       = out_is_new_r;
  assign out_red_out      = out_red_out_r;
  assign out_green_out    = out_green_out_r;
  assign out_blue_out     = out_blue_out_r;
  assign out_overflow     = out_overflow_r;
  assign out_entries_used = out_entries_used_r;

  // Checks
  `ECPI_ASSERT(a_count_bound, count_r <= CNT_FULL, "entry count above palette size")
  `ECPI_ASSERT(a_new_is_last,
    out_valid_r && out_is_new_r |->
      (CNT_W'(out_color_index_r) + 1'b1) == out_entries_used_r,
    "new entry not at end of palette")
  `ECPI_ASSERT(a_ovf_result,
    out_valid_r && out_overflow_r |->
      out_color_index_r == '0 && !out_is_new_r &&
      out_entries_used_r == CNT_W'(PALETTE_ENTRIES),
    "bad overflow result")
  `ECPI_ASSERT(a_accept_scan, in_accept |=> state_r == ST_SCAN, "accepted item did not start a scan")
  `ECPI_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid_r && state_r == ST_IDLE, "reset left block busy")

endmodule
`default_nettype wire

>>> test/palette_index_checker.sv
// Scoreboard for the palette indexer: predicts every lookup and compares each result item
`timescale 1ns / 100ps
module palette_index_checker #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [ecpi_pkg::PIXEL_W-1:0] in_pixel,
  input  logic                         in_start_image,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ecpi_pkg::IDX_W-1:0]   out_color_index,
  input  logic                         out_is_new,
  input  logic [ecpi_pkg::CHAN_W-1:0]  out_red_out,
  input  logic [ecpi_pkg::CHAN_W-1:0]  out_green_out,
  input  logic [ecpi_pkg::CHAN_W-1:0]  out_blue_out,
  input  logic                         out_overflow,
  input  logic [ecpi_pkg::CNT_W-1:0]   out_entries_used,
  output int                           mismatch_count,
  output int                           pending_results
);
  import ecpi_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]  color_index;
    logic              is_new;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              overflow;
    logic [CNT_W-1:0]  entries_used;
  } lookup_result_t;

  // Own copy of the palette, only entries below palette_fill are meaningful
  logic [COLOR_W-1:0] palette_keys [PALETTE_ENTRIES];
  int                 palette_fill;
  lookup_result_t     pending_lookups[$];
  int                 errors;

  initial begin
    errors = 0;
    palette_fill = 0;
    mismatch_count = 0;
    pending_results = 0;
  end

  // Widen a 5-bit component: shift up and fill the low bits from its top
  function automatic logic [CHAN_W-1:0] widen_component(input logic [COMP_W-1:0] c);
    logic [CHAN_W-1:0] wide;
    wide = CHAN_W'(c) << 3;
    wide = wide | CHAN_W'(c >> 2);
    return wide;
  endfunction

  // Search the palette lowest index first, append on a miss, flag overflow when full
  function automatic lookup_result_t index_pixel(input logic [PIXEL_W-1:0] px,
                                                 input logic start);
    lookup_result_t     res;
    logic [COLOR_W-1:0] key;
    int                 hit;
    key = {px[15:11], px[10:6], px[4:0]};
    if (start) palette_fill = 0;
    hit = -1;
    for (int i = 0; i < palette_fill; i++) begin
      if (hit < 0 && palette_keys[i] == key) hit = i;
    end
    res.red          = widen_component(px[15:11]);
    res.green        = widen_component(px[10:6]);
    res.blue         = widen_component(px[4:0]);
    res.is_new       = 1'b0;
    res.overflow     = 1'b0;
    if (hit >= 0) begin
      res.color_index = IDX_W'(hit);
    end else if (palette_fill < PALETTE_ENTRIES) begin
      palette_keys[palette_fill] = key;
      res.color_index = IDX_W'(palette_fill);
      palette_fill++;
      res.is_new = 1'b1;
    end else begin
      res.color_index = '0;
      res.overflow    = 1'b1;
    end
    res.entries_used = CNT_W'(palette_fill);
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Watch both channels at each edge: retire result items, then queue predictions
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      palette_fill = 0;
      pending_lookups.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_lookups.size() == 0) begin
          $error("result item with no pixel pending: color_index %0d", out_color_index);
          errors++;
        end else begin
          want = pending_lookups.pop_front();
          compare_field("color_index", want.color_index, out_color_index);
          compare_field("is_new", want.is_new, out_is_new);
          compare_field("red_out", want.red, out_red_out);
          compare_field("green_out", want.green, out_green_out);
          compare_field("blue_out", want.blue, out_blue_out);
          compare_field("overflow", want.overflow, out_overflow);
          compare_field("entries_used", want.entries_used, out_entries_used);
        end
      end
      if (in_valid && !in_stall) begin
        pending_lookups.push_back(index_pixel(in_pixel, in_start_image));
      end
    end
    mismatch_count  <= errors;
    pending_results <= pending_lookups.size();
  end

endmodule

>>> test/testbench.sv
// Top of the palette indexer test: clock, reset, pixel stimulus, stalls and verdict
`timescale 1ns / 100ps
module testbench;
  import ecpi_pkg::*;

  localparam int PALETTE_ENTRIES = 256;
  localparam int TOTAL_PIXELS    = 1650;
  localparam int QUIET_TAIL      = 150;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [PIXEL_W-1:0]  in_pixel;
  logic                in_start_image;
  logic                out_valid;
  logic                out_stall;
  logic [IDX_W-1:0]    out_color_index;
  logic                out_is_new;
  logic [CHAN_W-1:0]   out_red_out;
  logic [CHAN_W-1:0]   out_green_out;
  logic [CHAN_W-1:0]   out_blue_out;
  logic                out_overflow;
  logic [CNT_W-1:0]    out_entries_used;
  int                  mismatch_count;
  int                  pending_results;

  int pixels_sent;
  bit quiet;
  bit gaps_on;

  exact_color_palette_indexer_unit #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .in_start_image   (in_start_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_color_index  (out_color_index),
    .out_is_new       (out_is_new),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_overflow     (out_overflow),
    .out_entries_used (out_entries_used)
  );

  palette_index_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .in_start_image   (in_start_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_color_index  (out_color_index),
    .out_is_new       (out_is_new),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_overflow     (out_overflow),
    .out_entries_used (out_entries_used),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one pixel, sometimes after a short gap, and hold it until accepted
  task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic start);
    int gap;
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_start_image <= start;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    if (pixels_sent >= TOTAL_PIXELS - QUIET_TAIL) quiet = 1'b1;
  endtask

  // Hold off the sender until every predicted result item has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  function automatic logic [PIXEL_W-1:0] key_to_pixel(input logic [COLOR_W-1:0] key,
                                                      input logic spare_bit);
    return {key[14:10], key[9:5], spare_bit, key[4:0]};
  endfunction

  // One image over a set of distinct colours: an odd stride walks the colour
  // space without repeats. Either fill the palette in order first, or scatter.
  task automatic run_image(input int n_colors, input int tail_len, input bit fill_first);
    logic [COLOR_W-1:0] base;
    logic [COLOR_W-1:0] stride;
    int                 pick;
    logic               start;
    base   = COLOR_W'($urandom_range(0, 32767));
    stride = COLOR_W'($urandom_range(0, 32767)) | COLOR_W'(1);
    if (fill_first) begin
      for (int i = 0; i < n_colors; i++) begin
        send_pixel(key_to_pixel(COLOR_W'(base + COLOR_W'(i) * stride),
                                1'($urandom_range(0, 1))), 1'(i == 0));
      end
    end
    for (int j = 0; j < tail_len; j++) begin
      if (fill_first) pick = $urandom_range(0, n_colors + n_colors / 8);
      else pick = $urandom_range(0, n_colors - 1);
      start = (j == 0 && !fill_first) || $urandom_range(0, 39) == 0;
      send_pixel(key_to_pixel(COLOR_W'(base + COLOR_W'(pick) * stride),
                              1'($urandom_range(0, 1))), start);
    end
  endtask

  // Result side: random stall bursts between free stretches, none at the tail
  initial begin
    out_stall <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int kind;
    int burst;
    in_valid       <= 1'b0;
    in_pixel       <= '0;
    in_start_image <= 1'b0;
    rst_n          <= 1'b0;
    pixels_sent = 0;
    quiet       = 1'b0;
    gaps_on     = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: black and white, the spare bit, each component at full scale,
    // repeats that must hit, and start of image on fresh and repeated colours
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h0020, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFDF, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07C0, 1'b0);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'h8421, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hFFDF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h0020, 1'b1);
    drain_results();

    // Fill the whole palette, then mix hits across the palette with overflowing misses
    run_image(PALETTE_ENTRIES, 40, 1'b1);

    while (pixels_sent < TOTAL_PIXELS) begin
      gaps_on = $urandom_range(0, 3) != 0;
      kind    = $urandom_range(0, 99);
      if (kind < 5 && pixels_sent < TOTAL_PIXELS - 400) begin
        run_image($urandom_range(200, PALETTE_ENTRIES), $urandom_range(20, 60), 1'b1);
      end else if (kind < 15) begin
        burst = $urandom_range(5, 20);
        repeat (burst) begin
          send_pixel(PIXEL_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 9) == 0));
        end
      end else begin
        run_image($urandom_range(1, 32), $urandom_range(5, 60), 1'b0);
      end
      if (!quiet && $urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout guard
  initial begin
    #25ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
